@@ src/sehg_pkg.sv @@
package sehg_pkg;

  localparam int CW    = 32;          // coordinate width
  localparam int DMW   = 32;          // |b - a| per axis
  localparam int SW    = 66;          // squared length, Q34.32
  localparam int LW    = 34;          // length register width
  localparam int EW    = 33;          // |l - l0|
  localparam int KW    = 32;          // stiffness / rest length
  localparam int OW    = 48;          // signed outputs
  localparam int ENW   = 47;          // energy
  localparam int MAGW  = 96;          // magnitude fed to saturation

  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_STIFFNESS   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_REST_LENGTH = IDX_W'(1);
  localparam logic [KW-1:0]    STIFFNESS_RST   = 32'h0001_0000;
  localparam logic [KW-1:0]    REST_LENGTH_RST = 32'h0000_0000;

  localparam int QUEUE_DEPTH = 2;

  localparam int IN_TDATA_W  = 6 * CW;
  localparam int OUT_TDATA_W = 480;
  localparam int OUT_TUSER_W = 1;

  localparam int HESS_I [6] = '{0, 0, 0, 1, 1, 2};
  localparam int HESS_J [6] = '{0, 1, 2, 1, 2, 2};

  localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] NEG_MAX = {1'b1, {(OW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][DMW-1:0] dm;
    logic [2:0]          dn;
    logic                degen;
  } sehg_item_t;

  typedef struct packed {
    logic                degenerate;
    logic [5:0][OW-1:0]  hess;
    logic [2:0][OW-1:0]  grad;
    logic [ENW-1:0]      energy;
  } sehg_result_t;

  function automatic logic [OW-1:0] sat_signed(input logic [MAGW-1:0] mag, input logic neg);
    logic [OW-1:0] r;
    if (neg) begin
      if (mag > {{(MAGW-OW){1'b0}}, NEG_MAX}) r = NEG_MAX;
      else r = ~mag[OW-1:0] + OW'(1);
    end else begin
      if (mag > {{(MAGW-OW){1'b0}}, POS_MAX}) r = POS_MAX;
      else r = mag[OW-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/spring_energy_gradient_hessian_top.sv @@
// Linear spring energy, gradient and Hessian block. One spring (two endpoints,
// signed Q16.16) goes in per transfer and one result comes out per transfer:
// energy 0.5*k*(l-l0)^2, gradient k*(l-l0)*d/l and the six unique entries of
// the 3x3 Hessian block, all saturating, with a degenerate flag for zero length
// and nonzero rest length. A new spring is accepted every cycle while the
// output is not held back. The pipeline chains a 34-stage square root, a
// 96-stage and a 66-stage restoring divider, one quotient bit per stage. A
// two-entry input queue keeps accepting while the output waits, until it is
// full. Write stiffness and rest length only while the block is empty.
module spring_energy_gradient_hessian_top import sehg_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // energy, grad_x, grad_y, grad_z, hess_xx, hess_xy, hess_xz, hess_yy,
  // hess_yz, hess_zz, one zero pad bit
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // degenerate
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IDX_W-1:0]       cfg_index_i,
  input  logic [KW-1:0]          cfg_data_i
);

  logic [KW-1:0] stiffness_q, rest_length_q;
  logic          avail, pop;
  sehg_item_t    item;
  sehg_result_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q   <= STIFFNESS_RST;
      rest_length_q <= REST_LENGTH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STIFFNESS:   stiffness_q   <= cfg_data_i;
        REG_REST_LENGTH: rest_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sehg_front #(.Depth(QueueDepth)) u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .rest_nz_i (rest_length_q != '0),
    .pop_i     (pop),
    .avail_o   (avail),
    .item_o    (item)
  );

  sehg_back u_back (
    .clk_i,
    .rst_ni,
    .stiffness_i   (stiffness_q),
    .rest_length_i (rest_length_q),
    .avail_i       (avail),
    .item_i        (item),
    .pop_o         (pop),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {1'b0, res.hess[5], res.hess[4], res.hess[3], res.hess[2],
                         res.hess[1], res.hess[0], res.grad[2], res.grad[1],
                         res.grad[0], res.energy};
  assign m_axis_tuser = res.degenerate;

endmodule

@@ src/sehg_delay.sv @@
module sehg_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  for (genvar i = 0; i < N; i++) begin : g_tap
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tap_q[i] <= (i == 0) ? d_i : tap_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

@@ src/sehg_mul.sv @@
module sehg_mul #(
  parameter int AW  = 32,
  parameter int BW  = 32,
  parameter int CHW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int NC = (AW + CHW - 1) / CHW;
  localparam int AP = NC * CHW;
  localparam int PW = AW + BW;
  localparam int XW = AP + BW;

  logic [AP-1:0] a_q   [NC];
  logic [BW-1:0] b_q   [NC];
  logic [PW-1:0] acc_q [NC];

  // one chunk of a per stage
  for (genvar j = 0; j < NC; j++) begin : g_stage
    logic [AP-1:0]      a_src;
    logic [BW-1:0]      b_src;
    logic [PW-1:0]      acc_src;
    logic [CHW+BW-1:0]  pp;
    logic [XW-1:0]      term;

    if (j == 0) begin : g_first
      assign a_src   = AP'(a_i);
      assign b_src   = b_i;
      assign acc_src = '0;
    end else begin : g_next
      assign a_src   = a_q[j-1];
      assign b_src   = b_q[j-1];
      assign acc_src = acc_q[j-1];
    end

    assign pp   = a_src[j*CHW +: CHW] * b_src;
    assign term = XW'(pp) << (j * CHW);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[j]   <= a_src;
        b_q[j]   <= b_src;
        acc_q[j] <= acc_src + PW'(term);
      end
    end
  end

  assign p_o = acc_q[NC-1];

endmodule

@@ src/sehg_div.sv @@
module sehg_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [NW-1:0] q_o
);

  // restoring division, one quotient bit per stage; quotient shifts in
  // where the numerator shifts out
  logic [NW-1:0] nq_q [NW];
  logic [DW-1:0] r_q  [NW];
  logic [DW-1:0] d_q  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [NW-1:0] nq_src;
    logic [DW-1:0] r_src;
    logic [DW-1:0] d_src;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fit;

    if (i == 0) begin : g_first
      assign nq_src = n_i;
      assign r_src  = '0;
      assign d_src  = d_i;
    end else begin : g_next
      assign nq_src = nq_q[i-1];
      assign r_src  = r_q[i-1];
      assign d_src  = d_q[i-1];
    end

    assign trial = {r_src, nq_src[NW-1]};
    assign fit   = trial >= {1'b0, d_src};
    assign diff  = trial - {1'b0, d_src};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[i] <= {nq_src[NW-2:0], fit};
        r_q[i]  <= fit ? diff[DW-1:0] : trial[DW-1:0];
        d_q[i]  <= d_src;
      end
    end
  end

  assign q_o = nq_q[NW-1];

endmodule

@@ src/sehg_sqrt.sv @@
module sehg_sqrt import sehg_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] s_i,
  output logic [LW-1:0] root_o
);

  localparam int PAD = 2 * LW;
  localparam int RW  = LW + 3;

  logic [PAD-1:0] s_q [LW];
  logic [LW-1:0]  q_q [LW];
  logic [RW-1:0]  r_q [LW];

  for (genvar i = 0; i < LW; i++) begin : g_stage
    logic [PAD-1:0] s_src;
    logic [LW-1:0]  q_src;
    logic [RW-1:0]  r_src;
    logic [RW-1:0]  r2;
    logic [RW-1:0]  t;
    logic           fit;

    if (i == 0) begin : g_first
      assign s_src = PAD'(s_i);
      assign q_src = '0;
      assign r_src = '0;
    end else begin : g_next
      assign s_src = s_q[i-1];
      assign q_src = q_q[i-1];
      assign r_src = r_q[i-1];
    end

    assign r2  = {r_src[RW-3:0], s_src[PAD-1 -: 2]};
    assign t   = RW'({q_src, 2'b01});
    assign fit = r2 >= t;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[i] <= {s_src[PAD-3:0], 2'b00};
        q_q[i] <= {q_src[LW-2:0], fit};
        r_q[i] <= fit ? (r2 - t) : r2;
      end
    end
  end

  assign root_o = q_q[LW-1];

endmodule

@@ src/sehg_front.sv @@
module sehg_front import sehg_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  rest_nz_i,
  input  logic                  pop_i,
  output logic                  avail_o,
  output sehg_item_t            item_o
);

  localparam int PTW  = $clog2(Depth);
  localparam int CNTW = $clog2(Depth + 1);

  sehg_item_t      mem_q [Depth];
  sehg_item_t      item_d;
  logic [PTW-1:0]  wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;
  logic [CW:0]     diff [3];
  logic            push;

  always_comb begin
    item_d = '0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {s_axis_tdata[(3+i)*CW+CW-1], s_axis_tdata[(3+i)*CW +: CW]}
              - {s_axis_tdata[i*CW+CW-1], s_axis_tdata[i*CW +: CW]};
      item_d.dn[i] = diff[i][CW];
      item_d.dm[i] = diff[i][CW] ? DMW'(~diff[i] + (CW+1)'(1)) : diff[i][DMW-1:0];
    end
    item_d.degen = rest_nz_i && (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0);
  end

  assign s_axis_tready = cnt_q != CNTW'(Depth);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign avail_o       = cnt_q != '0;
  assign item_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTW'(Depth-1)) ? '0 : wr_q + PTW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTW'(Depth-1)) ? '0 : rd_q + PTW'(1);
      end
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + CNTW'(1);
        2'b01:   cnt_q <= cnt_q - CNTW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/sehg_back.sv @@
module sehg_back import sehg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [KW-1:0] stiffness_i,
  input  logic [KW-1:0] rest_length_i,
  input  logic          avail_i,
  input  sehg_item_t    item_i,
  output logic          pop_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output sehg_result_t  res_o
);

  localparam int PW2   = 2 * DMW;             // pair products
  localparam int L2W   = 2 * LW;
  localparam int ESQW  = 2 * EW;
  localparam int E2KW  = ESQW + KW;
  localparam int KEW   = EW + KW;
  localparam int GNW   = KEW + DMW;
  localparam int GQW   = GNW - 16;
  localparam int UNW   = PW2 + 32;
  localparam int UW    = LW;                  // quotient u stays below 2^34
  localparam int ULW   = UW + KW;
  localparam int VKW   = ULW + KW;
  localparam int AMW   = VKW - 32;
  localparam int HSW   = AMW + 1;

  localparam int LAT_E2K = (ESQW + KW - 1) / KW;
  localparam int LAT_GN  = (KEW + KW - 1) / KW;
  localparam int LAT_VK  = (ULW + KW - 1) / KW;

  localparam int T_S   = 2;
  localparam int T_L   = T_S + LW;
  localparam int T_E   = T_L + 1;
  localparam int T_KE  = T_E + 1;
  localparam int T_EN  = T_KE + LAT_E2K;
  localparam int T_BM  = T_KE + KEW;
  localparam int T_GN  = T_KE + LAT_GN;
  localparam int T_GQ  = T_GN + GQW;
  localparam int T_U   = T_E + UNW;
  localparam int T_UL  = T_U + 1;
  localparam int T_V   = T_UL + ULW;
  localparam int T_VK  = T_V + LAT_VK;
  localparam int T_OUT = T_VK + 1;

  logic                adv;
  logic [T_OUT:0]      vld_q;

  logic [DMW-1:0]      dm0_q [3];
  logic [2:0]          dn0_q;
  logic                dg0_q;

  logic [PW2-1:0]      p6 [6];
  logic [PW2-1:0]      zg [3];
  logic [SW-1:0]       s_q;
  logic [LW-1:0]       len;
  logic [EW-1:0]       em_q;
  logic                en_q;
  logic [L2W-1:0]      l2;
  logic [ESQW-1:0]     esq;
  logic [E2KW-1:0]     e2k;
  logic [ENW-1:0]      energy_sat;
  logic [KEW-1:0]      ke;
  logic [KEW-1:0]      bmag;
  logic [LW-1:0]       l_ke, l_gn, l_ul;
  logic [DMW-1:0]      dm_ke [3];
  logic [GNW-1:0]      gnum [3];
  logic [GQW-1:0]      gq [3];
  logic [PW2-1:0]      p6_e [6];
  logic [UNW-1:0]      uq [6];
  logic [ULW-1:0]      ul [6];
  logic [ULW-1:0]      vq [6];
  logic [VKW-1:0]      vk [6];

  logic [3:0]          flg_t;
  logic                en_t;
  logic [ENW-1:0]      energy_t;
  logic [KEW-1:0]      bmag_t;
  logic [GQW-1:0]      gq_t [3];
  logic [OW-1:0]       zg_t [3];
  logic [HSW-1:0]      hsum [6];
  logic                hneg [6];
  logic                zmode;
  sehg_result_t        res_d, res_q;

  assign adv   = !vld_q[T_OUT] || res_ready_i;
  assign pop_o = adv && avail_i;
  assign zmode = rest_length_i == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[T_OUT-1:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dm0_q[i] <= item_i.dm[i];
      end
      dn0_q <= item_i.dn;
      dg0_q <= item_i.degen;
    end
  end

  for (genvar e = 0; e < 6; e++) begin : g_pair
    sehg_mul #(.AW(DMW), .BW(DMW), .CHW(DMW)) u_pp (
      .clk_i, .en_i(adv), .a_i(dm0_q[HESS_I[e]]), .b_i(dm0_q[HESS_J[e]]), .p_o(p6[e])
    );
    sehg_delay #(.W(PW2), .N(T_E-1)) u_p6_dly (
      .clk_i, .en_i(adv), .d_i(p6[e]), .q_o(p6_e[e])
    );
    sehg_div #(.NW(UNW), .DW(L2W)) u_udiv (
      .clk_i, .en_i(adv), .n_i({p6_e[e], 32'h0}), .d_i(l2), .q_o(uq[e])
    );
    sehg_mul #(.AW(UW), .BW(KW), .CHW(UW)) u_ul (
      .clk_i, .en_i(adv), .a_i(uq[e][UW-1:0]), .b_i(rest_length_i), .p_o(ul[e])
    );
    sehg_div #(.NW(ULW), .DW(LW)) u_vdiv (
      .clk_i, .en_i(adv), .n_i(ul[e]), .d_i(l_ul), .q_o(vq[e])
    );
    sehg_mul #(.AW(ULW), .BW(KW), .CHW(KW)) u_vk (
      .clk_i, .en_i(adv), .a_i(vq[e]), .b_i(stiffness_i), .p_o(vk[e])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= SW'(p6[0]) + SW'(p6[3]) + SW'(p6[5]);
    end
  end

  sehg_sqrt u_sqrt (.clk_i, .en_i(adv), .s_i(s_q), .root_o(len));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      en_q <= len < LW'(rest_length_i);
      em_q <= (len < LW'(rest_length_i)) ? EW'(LW'(rest_length_i) - len)
                                          : EW'(len - LW'(rest_length_i));
    end
  end

  sehg_mul #(.AW(LW), .BW(LW), .CHW(LW)) u_l2 (
    .clk_i, .en_i(adv), .a_i(len), .b_i(len), .p_o(l2)
  );

  sehg_mul #(.AW(EW), .BW(EW), .CHW(EW)) u_esq (
    .clk_i, .en_i(adv), .a_i(em_q), .b_i(em_q), .p_o(esq)
  );
  sehg_mul #(.AW(ESQW), .BW(KW), .CHW(KW)) u_e2k (
    .clk_i, .en_i(adv), .a_i(esq), .b_i(stiffness_i), .p_o(e2k)
  );
  assign energy_sat = (e2k[E2KW-1:ENW+33] != '0) ? {ENW{1'b1}} : e2k[ENW+32:33];

  sehg_mul #(.AW(EW), .BW(KW), .CHW(EW)) u_ke (
    .clk_i, .en_i(adv), .a_i(em_q), .b_i(stiffness_i), .p_o(ke)
  );

  sehg_delay #(.W(LW), .N(T_KE-T_L)) u_l_ke (.clk_i, .en_i(adv), .d_i(len), .q_o(l_ke));
  sehg_delay #(.W(LW), .N(T_GN-T_L)) u_l_gn (.clk_i, .en_i(adv), .d_i(len), .q_o(l_gn));
  sehg_delay #(.W(LW), .N(T_UL-T_L)) u_l_ul (.clk_i, .en_i(adv), .d_i(len), .q_o(l_ul));

  sehg_div #(.NW(KEW), .DW(LW)) u_bdiv (
    .clk_i, .en_i(adv), .n_i(ke), .d_i(l_ke), .q_o(bmag)
  );

  for (genvar i = 0; i < 3; i++) begin : g_axis
    sehg_mul #(.AW(KW), .BW(DMW), .CHW(KW)) u_zg (
      .clk_i, .en_i(adv), .a_i(stiffness_i), .b_i(dm0_q[i]), .p_o(zg[i])
    );
    sehg_delay #(.W(OW), .N(T_VK-1)) u_zg_dly (
      .clk_i, .en_i(adv), .d_i(zg[i][PW2-1:16]), .q_o(zg_t[i])
    );
    sehg_delay #(.W(DMW), .N(T_KE)) u_dm_dly (
      .clk_i, .en_i(adv), .d_i(dm0_q[i]), .q_o(dm_ke[i])
    );
    sehg_mul #(.AW(KEW), .BW(DMW), .CHW(KW)) u_gn (
      .clk_i, .en_i(adv), .a_i(ke), .b_i(dm_ke[i]), .p_o(gnum[i])
    );
    sehg_div #(.NW(GQW), .DW(LW)) u_gdiv (
      .clk_i, .en_i(adv), .n_i(gnum[i][GNW-1:16]), .d_i(l_gn), .q_o(gq[i])
    );
    sehg_delay #(.W(GQW), .N(T_VK-T_GQ)) u_gq_dly (
      .clk_i, .en_i(adv), .d_i(gq[i]), .q_o(gq_t[i])
    );
  end

  sehg_delay #(.W(4), .N(T_VK)) u_flg_dly (
    .clk_i, .en_i(adv), .d_i({dg0_q, dn0_q}), .q_o(flg_t)
  );
  sehg_delay #(.W(1), .N(T_VK-T_E)) u_en_dly (
    .clk_i, .en_i(adv), .d_i(en_q), .q_o(en_t)
  );
  sehg_delay #(.W(ENW), .N(T_VK-T_EN)) u_energy_dly (
    .clk_i, .en_i(adv), .d_i(energy_sat), .q_o(energy_t)
  );
  sehg_delay #(.W(KEW), .N(T_VK-T_BM)) u_bmag_dly (
    .clk_i, .en_i(adv), .d_i(bmag), .q_o(bmag_t)
  );

  // n n^T part plus the diagonal stretch term, signed magnitude
  always_comb begin
    for (int e = 0; e < 6; e++) begin
      hneg[e] = flg_t[HESS_I[e]] ^ flg_t[HESS_J[e]];
      hsum[e] = HSW'(vk[e][VKW-1:32]);
      if (HESS_I[e] == HESS_J[e]) begin
        if (hneg[e] == en_t) begin
          hsum[e] = HSW'(vk[e][VKW-1:32]) + HSW'(bmag_t);
        end else if (HSW'(vk[e][VKW-1:32]) >= HSW'(bmag_t)) begin
          hsum[e] = HSW'(vk[e][VKW-1:32]) - HSW'(bmag_t);
        end else begin
          hsum[e] = HSW'(bmag_t) - HSW'(vk[e][VKW-1:32]);
          hneg[e] = en_t;
        end
      end
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.energy = energy_t;
    if (zmode) begin
      for (int i = 0; i < 3; i++) begin
        res_d.grad[i] = sat_signed(MAGW'(zg_t[i]), flg_t[i]);
      end
      for (int e = 0; e < 6; e++) begin
        res_d.hess[e] = (HESS_I[e] == HESS_J[e]) ? OW'(stiffness_i) : '0;
      end
    end else if (flg_t[3]) begin
      res_d.degenerate = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        res_d.grad[i] = sat_signed(MAGW'(gq_t[i]), en_t ^ flg_t[i]);
      end
      for (int e = 0; e < 6; e++) begin
        res_d.hess[e] = sat_signed(MAGW'(hsum[e]), hneg[e]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = vld_q[T_OUT];
  assign res_o       = res_q;

endmodule

@@ test/tb_spring_energy_gradient_hessian_top.sv @@
`timescale 1ns / 1ps

module tb_spring_energy_gradient_hessian_top;
  import sehg_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNMAPPED = IDX_W'(3);
  localparam int unsigned DRAIN_CYCLES = 260;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned RANDOM_SPRINGS = 1800;

  typedef logic [191:0] wide_t;

  typedef struct {
    logic                new_cfg;
    logic [KW-1:0]       k;
    logic [KW-1:0]       l0;
    logic [5:0][CW-1:0]  pts;
    logic                typed;
    sehg_result_t        res;
  } spring_row_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i;
  logic [KW-1:0] cfg_data_i;

  logic [KW-1:0] stiff_q;
  logic [KW-1:0] rest_q;
  sehg_result_t spring_q[$];
  int unsigned errors;
  logic calm;
  int unsigned quiet_cycles;

  spring_energy_gradient_hessian_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [OW-1:0] clamp48(input wide_t mag, input logic neg);
    if (neg) begin
      if (mag > wide_t'(NEG_MAX)) return NEG_MAX;
      return OW'(~mag + 1);
    end
    if (mag > wide_t'(POS_MAX)) return POS_MAX;
    return mag[OW-1:0];
  endfunction

  function automatic sehg_result_t spring_response(input logic [5:0][CW-1:0] p);
    sehg_result_t r;
    wide_t dm[3];
    logic dn[3];
    wide_t s, l, em, t, ke, l2, bmag, g, u, v, am, sum, c, k, l0;
    logic en, an, sn;
    longint d;
    int a, b;
    k = wide_t'(stiff_q);
    l0 = wide_t'(rest_q);
    s = '0;
    for (int i = 0; i < 3; i++) begin
      d = longint'($signed(p[3+i])) - longint'($signed(p[i]));
      dn[i] = d < 0;
      dm[i] = wide_t'(dn[i] ? -d : d);
      s += dm[i] * dm[i];
    end
    l = '0;
    for (int i = 33; i >= 0; i--) begin
      c = l | (wide_t'(1) << i);
      if (c * c <= s) l = c;
    end
    en = l < l0;
    em = en ? l0 - l : l - l0;
    t = (em * em * k) >> 33;
    r = '0;
    r.energy = (t > wide_t'(POS_MAX[ENW-1:0])) ? POS_MAX[ENW-1:0] : t[ENW-1:0];
    if (rest_q == '0) begin
      for (int i = 0; i < 3; i++) r.grad[i] = clamp48((k * dm[i]) >> 16, dn[i]);
      for (int i = 0; i < 6; i++) r.hess[i] = (HESS_I[i] == HESS_J[i]) ? OW'(stiff_q) : '0;
    end else if (l == '0) begin
      r.degenerate = 1'b1;
    end else begin
      ke = k * em;
      l2 = l * l;
      bmag = ke / l;
      for (int i = 0; i < 3; i++) begin
        g = (ke * dm[i]) / (l << 16);
        r.grad[i] = clamp48(g, en != dn[i]);
      end
      for (int i = 0; i < 6; i++) begin
        a = HESS_I[i];
        b = HESS_J[i];
        u = ((dm[a] * dm[b]) << 32) / l2;
        v = (u * l0) / l;
        am = (v * k) >> 32;
        an = dn[a] != dn[b];
        sum = am;
        sn = an;
        if (a == b) begin
          if (an == en) begin
            sum = am + bmag;
          end else if (am >= bmag) begin
            sum = am - bmag;
          end else begin
            sum = bmag - am;
            sn = en;
          end
        end
        r.hess[i] = clamp48(sum, sn);
      end
    end
    return r;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [KW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_STIFFNESS) stiff_q = val;
    else if (idx == REG_REST_LENGTH) rest_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (spring_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_spring(input logic [KW-1:0] k, input logic [KW-1:0] l0);
    wait_drained();
    write_reg(REG_STIFFNESS, k);
    write_reg(REG_REST_LENGTH, l0);
  endtask

  task automatic send_spring(input logic [5:0][CW-1:0] p, input logic typed,
                             input sehg_result_t res);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    spring_q.push_back(typed ? res : spring_response(p));
  endtask

  function automatic logic [CW-1:0] coord_offset(input logic [CW-1:0] base, input int span);
    return base + CW'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [5:0][CW-1:0] random_spring();
    logic [5:0][CW-1:0] p;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 6; i++) p[i] = $urandom();
    for (int i = 0; i < 3; i++) begin
      case (mode)
        4, 5: p[3+i] = coord_offset(p[i], 1 << 20);
        6, 7: p[3+i] = coord_offset(p[i], 1 << 14);
        8: p[3+i] = p[i];
        9: p[3+i] = coord_offset(p[i], 3);
        default: ;
      endcase
    end
    return p;
  endfunction

  function automatic logic [KW-1:0] random_reg(input logic is_rest);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return is_rest ? KW'(65536) : STIFFNESS_RST;
      3: return KW'($urandom_range(0, 1 << 20));
      default: return $urandom();
    endcase
  endfunction

  function automatic spring_row_t mk_row(input logic c, input logic [KW-1:0] k,
                                         input logic [KW-1:0] l0,
                                         input logic [5:0][CW-1:0] p);
    spring_row_t row;
    row.new_cfg = c;
    row.k = k;
    row.l0 = l0;
    row.pts = p;
    row.typed = 1'b0;
    row.res = '0;
    return row;
  endfunction

  localparam logic [CW-1:0] CMAX = 32'h7fff_ffff;
  localparam logic [CW-1:0] CMIN = 32'h8000_0000;
  localparam logic [CW-1:0] ONE = 32'h0001_0000;

  initial begin
    spring_row_t rows[$];
    spring_row_t row;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_STIFFNESS;
    cfg_data_i = '0;
    calm = 1'b0;
    errors = 0;
    stiff_q = STIFFNESS_RST;
    rest_q = REST_LENGTH_RST;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values, nothing written yet
    row = mk_row(0, '0, '0, '0);
    row.typed = 1'b1;
    row.res.hess[0] = OW'(ONE);
    row.res.hess[3] = OW'(ONE);
    row.res.hess[5] = OW'(ONE);
    rows.push_back(row);
    rows.push_back(mk_row(0, '0, '0, {CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}));
    rows.push_back(mk_row(0, '0, '0, {CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}));
    rows.push_back(mk_row(0, '0, '0, {32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0}));
    rows.push_back(mk_row(1, '1, '0, {CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}));
    rows.push_back(mk_row(0, '1, '0, {32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0}));
    row = mk_row(1, ONE, ONE, '0);
    row.typed = 1'b1;
    row.res.energy = ENW'(32768);
    row.res.degenerate = 1'b1;
    rows.push_back(row);
    rows.push_back(mk_row(0, ONE, ONE, {32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0}));
    rows.push_back(mk_row(0, ONE, ONE, {32'd0, 4 * ONE, 3 * ONE, 32'd0, 32'd0, 32'd0}));
    rows.push_back(mk_row(0, ONE, ONE, {32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0}));
    rows.push_back(mk_row(0, ONE, ONE, {32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0}));
    rows.push_back(mk_row(0, ONE, ONE, {-ONE, 32'd5, -32'd7, 32'd0, 32'd0, 32'd0}));
    row = mk_row(1, '1, '1, {CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    row.typed = 1'b1;
    row.res.energy = POS_MAX[ENW-1:0];
    row.res.degenerate = 1'b1;
    rows.push_back(row);
    rows.push_back(mk_row(0, '1, '1, {CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}));
    rows.push_back(mk_row(0, '1, '1, {32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0}));
    rows.push_back(mk_row(0, '1, '1, {32'd3, -32'd2, 32'd1, 32'd0, 32'd0, 32'd0}));
    rows.push_back(mk_row(1, '0, 32'd12345, {32'd9, 32'd8, 32'd7, 32'd1, 32'd2, 32'd3}));
    rows.push_back(mk_row(0, '0, 32'd12345, {CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}));

    foreach (rows[i]) begin
      if (rows[i].new_cfg) set_spring(rows[i].k, rows[i].l0);
      send_spring(rows[i].pts, rows[i].typed, rows[i].res);
    end

    // unmapped index must leave both registers alone
    wait_drained();
    write_reg(REG_UNMAPPED, 32'hdead_beef);
    send_spring({32'd0, 32'd0, 32'd3, 32'd0, 32'd0, 32'd0}, 1'b0, '0);

    for (int n = 0; n < RANDOM_SPRINGS; n++) begin
      if (n % 300 == 0) set_spring(random_reg(1'b0), random_reg(1'b1));
      if (n == 450) wait_drained();
      calm = (n >= 900 && n < 1100);
      send_spring(random_spring(), 1'b0, '0);
    end
    calm = 1'b0;

    wait_drained();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 29);
  end

  always @(posedge clk_i) begin
    sehg_result_t want;
    sehg_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.energy = m_axis_tdata[ENW-1:0];
      for (int i = 0; i < 3; i++) got.grad[i] = m_axis_tdata[ENW + OW*i +: OW];
      for (int i = 0; i < 6; i++) got.hess[i] = m_axis_tdata[ENW + OW*(3+i) +: OW];
      got.degenerate = m_axis_tuser[0];
      if (spring_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result transfer: expected none actual %h", $time, got);
      end else begin
        want = spring_q.pop_front();
        if (got.energy !== want.energy) begin
          errors++;
          $display("%0t energy: expected %h actual %h", $time, want.energy, got.energy);
        end
        for (int i = 0; i < 3; i++) begin
          if (got.grad[i] !== want.grad[i]) begin
            errors++;
            $display("%0t grad[%0d]: expected %h actual %h", $time, i, want.grad[i],
                     got.grad[i]);
          end
        end
        for (int i = 0; i < 6; i++) begin
          if (got.hess[i] !== want.hess[i]) begin
            errors++;
            $display("%0t hess[%0d]: expected %h actual %h", $time, i, want.hess[i],
                     got.hess[i]);
          end
        end
        if (got.degenerate !== want.degenerate) begin
          errors++;
          $display("%0t degenerate: expected %b actual %b", $time, want.degenerate,
                   got.degenerate);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
